/* rtl/core/scsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_pkg: shared constants and types of the slab allocator
// Class geometry, status codes and the queued word between front and back.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int NUM_SIZE_CLASSES = 5;
  localparam int SLABS_PER_CLASS  = 4;
  localparam int SLAB_BYTES       = 4096;
  localparam int FAST_DEPTH       = 32;

  localparam int GRAIN     = 16;
  localparam int BLK_HDR   = 24;
  localparam int SLAB_HDR  = 64;
  localparam int MAX_BLKS  = 63;
  localparam int LIVE_MAX  = 2047;

  localparam int CLS_W  = 3;
  localparam int SLAB_W = 2;
  localparam int BLK_W  = 6;
  localparam int LIVE_W = 11;
  localparam int ST_W   = 3;
  localparam int FILL_W = $clog2(FAST_DEPTH + 1);
  localparam int FIDX_W = (FAST_DEPTH > 1) ? $clog2(FAST_DEPTH) : 1;
  localparam int LIM_W  = 7;

  // block size rounded to the grain, per class
  localparam int BS0 = (BLK_HDR + (32 << 0) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int BS1 = (BLK_HDR + (32 << 1) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int BS2 = (BLK_HDR + (32 << 2) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int BS3 = (BLK_HDR + (32 << 3) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int BS4 = (BLK_HDR + (32 << 4) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int BS5 = (BLK_HDR + (32 << 5) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int BS6 = (BLK_HDR + (32 << 6) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int BS7 = (BLK_HDR + (32 << 7) + GRAIN - 1) / GRAIN * GRAIN;
  localparam int N0 = (SLAB_BYTES - SLAB_HDR) / BS0;
  localparam int N1 = (SLAB_BYTES - SLAB_HDR) / BS1;
  localparam int N2 = (SLAB_BYTES - SLAB_HDR) / BS2;
  localparam int N3 = (SLAB_BYTES - SLAB_HDR) / BS3;
  localparam int N4 = (SLAB_BYTES - SLAB_HDR) / BS4;
  localparam int N5 = (SLAB_BYTES - SLAB_HDR) / BS5;
  localparam int N6 = (SLAB_BYTES - SLAB_HDR) / BS6;
  localparam int N7 = (SLAB_BYTES - SLAB_HDR) / BS7;

  localparam logic [BLK_W-1:0] BLKS_IN [8] = '{
    BLK_W'((N0 > MAX_BLKS) ? MAX_BLKS : N0), BLK_W'((N1 > MAX_BLKS) ? MAX_BLKS : N1),
    BLK_W'((N2 > MAX_BLKS) ? MAX_BLKS : N2), BLK_W'((N3 > MAX_BLKS) ? MAX_BLKS : N3),
    BLK_W'((N4 > MAX_BLKS) ? MAX_BLKS : N4), BLK_W'((N5 > MAX_BLKS) ? MAX_BLKS : N5),
    BLK_W'((N6 > MAX_BLKS) ? MAX_BLKS : N6), BLK_W'((N7 > MAX_BLKS) ? MAX_BLKS : N7)
  };

  localparam logic [ST_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [ST_W-1:0] ST_OUT       = 3'd3;
  localparam logic [ST_W-1:0] ST_FREED     = 3'd4;

  typedef struct packed {
    logic              is_free;
    logic              zero;
    logic              big;
    logic [CLS_W-1:0]  cls;
    logic [SLAB_W-1:0] slab;
    logic [BLK_W-1:0]  blk;
  } req_t;

endpackage

/* rtl/core/size_class_slab_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_slab_allocator: segregated size-class slab allocator
// Grants and frees block handles over five size classes with slab backing.
// ----------------------------------------------------------------------------
// Requests enter on in_valid_i/in_stall_o: kind_i 0 allocates req_size_i
// bytes, kind_i 1 frees the handle on free_class_i/free_slab_i/free_block_i.
// Every request gives one result word on out_valid_o/out_stall_i with a
// status, the granted handle (zero unless granted) and the live count.
// A two-word queue sits between the classing front end and the engine, so
// requests keep arriving while the engine works or the receiver stalls.
// The engine finishes a free, a zero size or a too-large request in its
// dispatch state; a fast-cache grant reads the fast cache memory; a slab
// grant scans the slabs, one step per created slab visited newest first and
// one more to open a new slab, then pops the slab stack, with a stack memory
// read when the block was freed back onto it; out of slabs is found after the
// scan visits every created slab. The fast cache and stack memory reads are registered.
// A stalled receiver holds the result register; the engine then holds one
// more finished result and the queue fills before in_stall_o rises.
// Reset empties the queue, all caches and slabs, zeroes the live count and
// sets fast_limit to 32; no clearing pass is needed. cfg_we_i writes
// fast_limit from cfg_wdata_i; write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module size_class_slab_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [5:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [15:0]                 req_size_i,
  input  logic [scsa_pkg::CLS_W-1:0]  free_class_i,
  input  logic [scsa_pkg::SLAB_W-1:0] free_slab_i,
  input  logic [scsa_pkg::BLK_W-1:0]  free_block_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [scsa_pkg::ST_W-1:0]   status_o,
  output logic [scsa_pkg::CLS_W-1:0]  got_class_o,
  output logic [scsa_pkg::SLAB_W-1:0] got_slab_o,
  output logic [scsa_pkg::BLK_W-1:0]  got_block_o,
  output logic [scsa_pkg::LIVE_W-1:0] active_count_o
);
  import scsa_pkg::*;

  logic  q_valid;
  logic  q_pop;
  req_t  q_word;

  // intake and classing
  scsa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .req_size_i,
    .free_class_i, .free_slab_i, .free_block_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_word_o(q_word)
  );

  // allocation engine
  scsa_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_word_i(q_word),
    .out_valid_o, .out_stall_i, .status_o, .got_class_o, .got_slab_o,
    .got_block_o, .active_count_o
  );

endmodule

/* rtl/core/scsa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_front: request intake and size classing
// Rounds the size, picks the class and queues the word for the back end.
// ----------------------------------------------------------------------------
module scsa_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [15:0]                 req_size_i,
  input  logic [scsa_pkg::CLS_W-1:0]  free_class_i,
  input  logic [scsa_pkg::SLAB_W-1:0] free_slab_i,
  input  logic [scsa_pkg::BLK_W-1:0]  free_block_i,
  output logic                        q_valid_o,
  input  logic                        q_pop_i,
  output scsa_pkg::req_t              q_word_o
);
  import scsa_pkg::*;

  logic [16:0] rsize;
  req_t        word;
  req_t        slot_q [2];
  logic        rd_q, wr_q;
  logic [1:0]  cnt_q;
  logic        push;

  // classify: first class whose payload size (32 << class) holds the rounded size
  always_comb begin
    rsize        = ({1'b0, req_size_i} + 17'(GRAIN - 1)) & ~17'(GRAIN - 1);
    word         = '0;
    word.is_free = kind_i;
    word.zero    = (req_size_i == 16'd0);
    word.big     = (rsize > 17'(32 << (NUM_SIZE_CLASSES - 1)));
    word.slab    = free_slab_i;
    word.blk     = free_block_i;
    word.cls     = free_class_i;
    if (!kind_i) begin
      word.cls = '0;
      for (int c = NUM_SIZE_CLASSES - 1; c >= 0; c--) begin
        if (rsize <= 17'(32 << c)) word.cls = CLS_W'(c);
      end
    end
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = slot_q[rd_q];

  // two-entry queue
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

/* rtl/core/scsa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_back: allocation engine
// Serves fast caches and slab stacks one request at a time; holds the result.
// ----------------------------------------------------------------------------
module scsa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [5:0]                  cfg_wdata_i,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  scsa_pkg::req_t              q_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [scsa_pkg::ST_W-1:0]   status_o,
  output logic [scsa_pkg::CLS_W-1:0]  got_class_o,
  output logic [scsa_pkg::SLAB_W-1:0] got_slab_o,
  output logic [scsa_pkg::BLK_W-1:0]  got_block_o,
  output logic [scsa_pkg::LIVE_W-1:0] active_count_o
);
  import scsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_SCAN, S_POP, S_FRD1, S_FRD2, S_SRD1, S_SRD2
  } state_e;
  localparam int CS_W = CLS_W + SLAB_W;

  state_e            state_q;
  req_t              req_q;
  logic [SLAB_W-1:0] s_q;
  logic [SLAB_W:0]   k_q;
  logic              emit_q;
  logic [ST_W-1:0]   rst_q;
  logic [BLK_W-1:0]  rblk_q;
  logic [LIVE_W-1:0] live_q;
  logic [5:0]        lim_reg_q;
  logic [FILL_W-1:0] fill_q    [8];
  logic [SLAB_W:0]   created_q [8];
  logic [BLK_W-1:0]  cnt_q     [1 << CS_W];
  logic [BLK_W-1:0]  prist_q   [1 << CS_W];
  logic [CLS_W+FIDX_W-1:0]      fa_q;
  logic [CS_W+BLK_W-1:0]        sa_q;
  logic [SLAB_W+BLK_W-1:0]      frd_q;
  logic [BLK_W-1:0]             srd_q;
  logic [SLAB_W+BLK_W-1:0]      fast_mem  [1 << (CLS_W + FIDX_W)];
  logic [BLK_W-1:0]             stack_mem [1 << (CS_W + BLK_W)];

  logic              ov_q;
  logic [ST_W-1:0]   ost_q;
  logic [CLS_W-1:0]  ocls_q;
  logic [SLAB_W-1:0] oslab_q;
  logic [BLK_W-1:0]  oblk_q;
  logic [LIVE_W-1:0] olive_q;

  logic [CLS_W-1:0]  c;
  logic [CS_W-1:0]   sel;
  logic [CS_W-1:0]   sel_new;
  logic [BLK_W-1:0]  cnt_sel;
  logic [BLK_W-1:0]  nblk;
  logic [LIM_W-1:0]  lim;
  logic              fvalid;
  logic              to_fast;
  logic              to_stack;
  logic              free_ok;
  logic [BLK_W-1:0]  pop_i;
  logic              out_free;

  // select class, slab and limits for this cycle
  always_comb begin
    c        = req_q.cls;
    nblk     = BLKS_IN[c];
    sel      = (state_q == S_SCAN) ? {c, SLAB_W'(k_q - 1'b1)} : {c, s_q};
    sel_new  = {c, SLAB_W'(created_q[c])};
    cnt_sel  = cnt_q[sel];
    lim      = (LIM_W'(lim_reg_q) < LIM_W'(FAST_DEPTH)) ? LIM_W'(lim_reg_q)
                                                        : LIM_W'(FAST_DEPTH);
    fvalid   = (int'(c) < NUM_SIZE_CLASSES) && ((SLAB_W + 1)'(s_q) < created_q[c])
               && (req_q.blk < nblk);
    free_ok  = (state_q == S_DISP) && req_q.is_free && fvalid;
    to_fast  = free_ok && (LIM_W'(fill_q[c]) < lim);
    to_stack = free_ok && !to_fast && (cnt_sel < nblk);
    pop_i    = cnt_sel - 1'b1;
    out_free = !ov_q || !out_stall_i;
    q_pop_o  = (state_q == S_IDLE) && q_valid_i && !emit_q;
  end

  // fast cache memory
  always_ff @(posedge clk_i) begin
    if (to_fast) fast_mem[{c, FIDX_W'(fill_q[c])}] <= {s_q, req_q.blk};
    if (state_q == S_FRD1) frd_q <= fast_mem[fa_q];
  end

  // slab free stack memory
  always_ff @(posedge clk_i) begin
    if (to_stack) stack_mem[{sel, cnt_sel}] <= req_q.blk;
    if (state_q == S_SRD1) srd_q <= stack_mem[sa_q];
  end

  // sequence one request, then hand its result to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      s_q       <= '0;
      k_q       <= '0;
      rst_q     <= '0;
      rblk_q    <= '0;
      fa_q      <= '0;
      sa_q      <= '0;
      emit_q    <= 1'b0;
      ov_q      <= 1'b0;
      ost_q     <= '0;
      ocls_q    <= '0;
      oslab_q   <= '0;
      oblk_q    <= '0;
      olive_q   <= '0;
      live_q    <= '0;
      lim_reg_q <= 6'd32;
      for (int i = 0; i < 8; i++) begin
        fill_q[i]    <= '0;
        created_q[i] <= '0;
      end
      for (int i = 0; i < (1 << CS_W); i++) begin
        cnt_q[i]   <= '0;
        prist_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) lim_reg_q <= cfg_wdata_i;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (emit_q && out_free) begin
        ov_q    <= 1'b1;
        ost_q   <= rst_q;
        olive_q <= live_q;
        emit_q  <= 1'b0;
        if (rst_q == ST_GRANTED) begin
          ocls_q  <= c;
          oslab_q <= s_q;
          oblk_q  <= rblk_q;
        end else begin
          ocls_q  <= '0;
          oslab_q <= '0;
          oblk_q  <= '0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            req_q   <= q_word_i;
            s_q     <= q_word_i.slab;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          if (req_q.is_free) begin
            rst_q   <= ST_FREED;
            emit_q  <= 1'b1;
            state_q <= S_IDLE;
            if (fvalid && live_q != '0) live_q <= live_q - 1'b1;
            if (to_fast) fill_q[c] <= fill_q[c] + 1'b1;
            if (to_stack) begin
              cnt_q[sel] <= cnt_sel + 1'b1;
              if (cnt_sel < prist_q[sel]) prist_q[sel] <= cnt_sel;
            end
          end else if (req_q.zero || req_q.big) begin
            rst_q   <= req_q.zero ? ST_ZERO : ST_TOO_LARGE;
            emit_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (fill_q[c] != '0) begin
            fill_q[c] <= fill_q[c] - 1'b1;
            fa_q      <= {c, FIDX_W'(fill_q[c] - 1'b1)};
            state_q   <= S_FRD1;
          end else begin
            k_q     <= created_q[c];
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (k_q == '0) begin
            if (int'(created_q[c]) >= SLABS_PER_CLASS) begin
              rst_q   <= ST_OUT;
              emit_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              s_q              <= SLAB_W'(created_q[c]);
              created_q[c]     <= created_q[c] + 1'b1;
              cnt_q[sel_new]   <= nblk;
              prist_q[sel_new] <= nblk;
              if (nblk == '0) begin
                rst_q   <= ST_OUT;
                emit_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                state_q <= S_POP;
              end
            end
          end else if (cnt_sel != '0) begin
            s_q     <= SLAB_W'(k_q - 1'b1);
            state_q <= S_POP;
          end else begin
            k_q <= k_q - 1'b1;
          end
        end
        S_POP: begin
          cnt_q[sel] <= pop_i;
          if (pop_i < prist_q[sel]) begin
            rblk_q  <= pop_i;
            rst_q   <= ST_GRANTED;
            emit_q  <= 1'b1;
            if (live_q != LIVE_W'(LIVE_MAX)) live_q <= live_q + 1'b1;
            state_q <= S_IDLE;
          end else begin
            sa_q    <= {sel, pop_i};
            state_q <= S_SRD1;
          end
        end
        S_FRD1: state_q <= S_FRD2;
        S_FRD2: begin
          s_q     <= frd_q[BLK_W +: SLAB_W];
          rblk_q  <= frd_q[BLK_W-1:0];
          rst_q   <= ST_GRANTED;
          emit_q  <= 1'b1;
          if (live_q != LIVE_W'(LIVE_MAX)) live_q <= live_q + 1'b1;
          state_q <= S_IDLE;
        end
        S_SRD1: state_q <= S_SRD2;
        S_SRD2: begin
          rblk_q  <= srd_q;
          rst_q   <= ST_GRANTED;
          emit_q  <= 1'b1;
          if (live_q != LIVE_W'(LIVE_MAX)) live_q <= live_q + 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = ov_q;
  assign status_o       = ost_q;
  assign got_class_o    = ocls_q;
  assign got_slab_o     = oslab_q;
  assign got_block_o    = oblk_q;
  assign active_count_o = olive_q;

  // the class 0 fast cache never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q[0]) <= FAST_DEPTH)
    else $error("fast cache fill above depth");

  // the stack of class 0, slab 0 never holds more blocks than the slab has
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= BLKS_IN[0])
    else $error("slab stack count above block count");

  // results that are not grants carry a null handle
  a_null_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q != ST_GRANTED) |-> (ocls_q == '0 && oslab_q == '0 && oblk_q == '0))
    else $error("non-grant result carries a handle");

  // a new request is taken only once the previous result has left the engine
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> !emit_q)
    else $error("request taken while a result is pending");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for size_class_slab_allocator
// A directed table, then random allocate/free traffic with handle tracking,
// checked word by word against an in-bench allocator predictor.
// ----------------------------------------------------------------------------
module testbench;
  import scsa_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [ST_W-1:0]   st;
    logic [CLS_W-1:0]  cls;
    logic [SLAB_W-1:0] slab;
    logic [BLK_W-1:0]  blk;
    logic [LIVE_W-1:0] live;
  } grant_t;

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [2:0]  cls;
    logic [1:0]  slab;
    logic [5:0]  blk;
    bit          fixed;
    grant_t      want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0;
  logic [15:0] req_size_i = '0;
  logic [CLS_W-1:0] free_class_i = '0;
  logic [SLAB_W-1:0] free_slab_i = '0;
  logic [BLK_W-1:0] free_block_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ST_W-1:0] status_o;
  logic [CLS_W-1:0] got_class_o;
  logic [SLAB_W-1:0] got_slab_o;
  logic [BLK_W-1:0] got_block_o;
  logic [LIVE_W-1:0] active_count_o;

  size_class_slab_allocator DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0] pc_cache [NUM_SIZE_CLASSES][FAST_DEPTH];
  int         pc_fill  [NUM_SIZE_CLASSES];
  int         pc_made  [NUM_SIZE_CLASSES];
  int         pc_cnt   [NUM_SIZE_CLASSES][SLABS_PER_CLASS];
  logic [5:0] pc_stack [NUM_SIZE_CLASSES][SLABS_PER_CLASS][MAX_BLKS];
  int         pc_live;
  int         pc_limit;

  grant_t pending_words[$];
  row_t   dir_rows[$];
  logic [10:0] live_handles[$];   // {class, slab, block} held by the bench
  int errors = 0;
  int cycles = 0;
  int words_seen = 0;
  int send_idle = 9, recv_idle = 54;
  bit hold_recv = 1'b0;

  function automatic int blocks_of(int c);
    int bs, n;
    bs = (BLK_HDR + (32 << c) + GRAIN - 1) / GRAIN * GRAIN;
    n = (SLAB_BYTES - SLAB_HDR) / bs;
    return n > MAX_BLKS ? MAX_BLKS : n;
  endfunction

  function automatic void reset_allocator();
    for (int c = 0; c < NUM_SIZE_CLASSES; c++) begin
      pc_fill[c] = 0;
      pc_made[c] = 0;
      for (int s = 0; s < SLABS_PER_CLASS; s++) pc_cnt[c][s] = 0;
    end
    pc_live = 0;
    pc_limit = 32;
  endfunction

  function automatic grant_t serve_request(logic kind, logic [15:0] size, int c, int s, int b);
    grant_t g;
    int sz, k, lim;
    bit found;
    logic [7:0] h;
    g = '0;
    found = 0;
    if (kind == 1'b0) begin
      if (size == 0) begin
        g.st = ST_ZERO;
      end else begin
        sz = (int'(size) + 15) & ~15;
        for (c = 0; c < NUM_SIZE_CLASSES; c++) if (sz <= (32 << c)) break;
        if (c >= NUM_SIZE_CLASSES) begin
          g.st = ST_TOO_LARGE;
        end else if (pc_fill[c] > 0) begin
          pc_fill[c]--;
          h = pc_cache[c][pc_fill[c]];
          found = 1;
          s = h[7:6];
          b = h[5:0];
        end else begin
          for (k = pc_made[c]; k > 0; k--) begin
            if (pc_cnt[c][k-1] > 0) begin
              s = k - 1;
              found = 1;
              break;
            end
          end
          if (!found && pc_made[c] < SLABS_PER_CLASS) begin
            s = pc_made[c];
            pc_made[c]++;
            for (k = 0; k < blocks_of(c); k++) pc_stack[c][s][k] = 6'(k);
            pc_cnt[c][s] = blocks_of(c);
            found = 1;
          end
          if (found) begin
            pc_cnt[c][s]--;
            b = pc_stack[c][s][pc_cnt[c][s]];
          end else begin
            g.st = ST_OUT;
          end
        end
        if (found) begin
          if (pc_live < LIVE_MAX) pc_live++;
          g.st = ST_GRANTED;
          g.cls = CLS_W'(c);
          g.slab = SLAB_W'(s);
          g.blk = BLK_W'(b);
        end
      end
    end else begin
      g.st = ST_FREED;
      if (c < NUM_SIZE_CLASSES && s < pc_made[c] && b < blocks_of(c)) begin
        if (pc_live > 0) pc_live--;
        lim = pc_limit < FAST_DEPTH ? pc_limit : FAST_DEPTH;
        if (pc_fill[c] < lim) begin
          pc_cache[c][pc_fill[c]] = {s[1:0], b[5:0]};
          pc_fill[c]++;
        end else if (pc_cnt[c][s] < blocks_of(c)) begin
          pc_stack[c][s][pc_cnt[c][s]] = 6'(b);
          pc_cnt[c][s]++;
        end
      end
    end
    g.live = LIVE_W'(pc_live);
    return g;
  endfunction

  // offer one word and hold it until accepted
  task automatic send_word(logic kind, logic [15:0] size, logic [2:0] c, logic [1:0] s,
                           logic [5:0] b, bit fixed, grant_t want);
    grant_t g;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    req_size_i <= size;
    free_class_i <= c;
    free_slab_i <= s;
    free_block_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    g = serve_request(kind, size, c, s, b);
    if (g.st == ST_GRANTED) live_handles.push_back({g.cls, g.slab, g.blk});
    if (fixed && g != want) begin
      $display("%0t predictor disagrees with table: expected %h actual %h", $time, want, g);
      errors++;
    end
    pending_words.push_back(g);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(int v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 6'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pc_limit = v;
  endtask

  task automatic random_phase(int n);
    int r, idx;
    logic [10:0] h;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        // allocate, mostly legal sizes
        if ($urandom_range(9) == 0) send_word(0, 16'($urandom), 0, 0, 0, 0, '0);
        else send_word(0, 16'($urandom_range(512)), 0, 0, 0, 0, '0);
      end else if (r < 88 && live_handles.size() > 0) begin
        idx = $urandom_range(live_handles.size() - 1);
        h = live_handles[idx];
        live_handles.delete(idx);
        send_word(1, 16'($urandom), h[10:8], h[7:6], h[5:0], 0, '0);
      end else begin
        // noise: arbitrary handle, including repeated and invalid frees
        send_word(1, 16'($urandom), 3'($urandom), 2'($urandom), 6'($urandom), 0, '0);
      end
    end
  endtask

  // check result words
  always @(posedge clk_i) begin
    grant_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, got_class_o, got_slab_o, got_block_o, active_count_o};
      words_seen++;
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (got.st != want.st || got.cls != want.cls || got.slab != want.slab ||
            got.blk != want.blk || got.live != want.live) begin
          $display("%0t mismatch: expected st%0d c%0d s%0d b%0d n%0d",
                   $time, want.st, want.cls, want.slab, want.blk, want.live,
                   " actual st%0d c%0d s%0d b%0d n%0d",
                   got.st, got.cls, got.slab, got.blk, got.live);
          errors++;
        end
      end
    end
  end

  // drive receiver stall
  always @(posedge clk_i) begin
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic row_t mk(logic kind, logic [15:0] size, logic [2:0] c, logic [1:0] s,
                              logic [5:0] b, bit fixed, logic [2:0] st, int live);
    row_t r;
    r.kind = kind; r.size = size; r.cls = c; r.slab = s; r.blk = b; r.fixed = fixed;
    r.want = '0;
    r.want.st = st;
    r.want.live = LIVE_W'(live);
    return r;
  endfunction

  initial begin
    row_t r;
    reset_allocator();
    // free before any slab, zero, too large, extremes, every class
    dir_rows.push_back(mk(1, 16'h0, 0, 0, 0, 1, ST_FREED, 0));
    dir_rows.push_back(mk(0, 16'h0, 0, 0, 0, 1, ST_ZERO, 0));
    dir_rows.push_back(mk(0, 16'hffff, 0, 0, 0, 1, ST_TOO_LARGE, 0));
    dir_rows.push_back(mk(0, 16'd513, 0, 0, 0, 1, ST_TOO_LARGE, 0));
    dir_rows.push_back(mk(0, 16'd1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 16'd33, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 16'd100, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 16'd256, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 16'd512, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 16'h0, 7, 3, 63, 1, ST_FREED, 5));
    dir_rows.push_back(mk(1, 16'h0, 4, 3, 0, 1, ST_FREED, 5));
    dir_rows.push_back(mk(1, 16'h0, 4, 0, 7, 1, ST_FREED, 5));
    dir_rows.push_back(mk(1, 16'h0, 4, 0, 6, 0, 0, 0));
    dir_rows.push_back(mk(0, 16'd500, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 16'h0, 0, 0, 62, 0, 0, 0));
    dir_rows.push_back(mk(1, 16'h0, 0, 0, 62, 0, 0, 0));
    // more class 4 allocations; a class 4 slab holds 7 blocks, at most 4 slabs
    for (int i = 0; i < 9; i++) dir_rows.push_back(mk(0, 16'd400, 0, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_word(r.kind, r.size, r.cls, r.slab, r.blk, r.fixed, r.want);
    end
    random_phase(40);
    wait_drained();

    // limit zero: frees go straight to slab stacks, including repeated frees
    write_limit(0);
    for (int i = 0; i < 30; i++) send_word(0, 16'd400, 0, 0, 0, 0, '0);
    for (int i = 0; i < 12; i++)
      send_word(1, 0, 4, 2'($urandom_range(3)), 6'($urandom_range(6)), 0, '0);
    random_phase(300);
    wait_drained();

    // sender mostly idle, receiver rarely stalls
    write_limit(63);
    send_idle = 54; recv_idle = 9;
    random_phase(400);
    wait_drained();

    // long receiver hold while input keeps coming
    write_limit(3);
    send_idle = 0; recv_idle = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      random_phase(60);
    join
    random_phase(340);
    wait_drained();

    write_limit(32);
    random_phase(400);
    wait_drained();

    $display("Covered directed extremes, all classes, fast limits 0/3/32/63, %0d words.",
             words_seen);
    $display("Included slab exhaustion, invalid and repeated frees, and a long output hold.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
